// ===== sv/kpl_pkg.sv =====
`default_nettype none
package kpl_pkg;

   // Entry buffer size; one slot is reserved, so an entry holds ENTRY_BYTES-1 keys
   localparam int ENTRY_BYTES = 8;
   localparam int ENTRY_CAP   = ENTRY_BYTES - 1;
   localparam int LEN_W       = $clog2(ENTRY_BYTES);
   // initial_code carries seven bytes
   localparam int CODE_BYTES  = 7;
   localparam int LOAD_BYTES  = (ENTRY_CAP < CODE_BYTES) ? ENTRY_CAP : CODE_BYTES;

   localparam int TRIES_W     = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8 * CODE_BYTES;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TRIES = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_CODE = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_LEN  = CSR_INDEX_W'(2);

   localparam logic [TRIES_W-1:0] MAX_TRIES_RESET = TRIES_W'(3);
   localparam logic [TRIES_W-1:0] TRIES_SAT       = '1;

   localparam logic [7:0] KEY_NONE = 8'd0;
   localparam logic [7:0] KEY_END  = 8'd35;   // '#'

   typedef logic [7:0]       char_type;
   typedef logic [LEN_W-1:0] len_type;

   typedef enum logic [1:0] {
      OP_KEY    = 2'd0,
      OP_CHECK  = 2'd1,
      OP_CHANGE = 2'd2,
      OP_LOAD   = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IGNORED  = 4'd0,
      ST_ECHO     = 4'd1,
      ST_DROPPED  = 4'd2,
      ST_GRANTED  = 4'd3,
      ST_RETRY    = 4'd4,
      ST_LOCKED   = 4'd5,
      ST_OLD_BAD  = 4'd6,
      ST_ASK_NEW  = 4'd7,
      ST_ASK_CONF = 4'd8,
      ST_MISMATCH = 4'd9,
      ST_UPDATED  = 4'd10,
      ST_STARTED  = 4'd11
   } status_type;

   typedef struct packed {
      logic [TRIES_W-1:0]    max_tries;
      logic [CSR_DATA_W-1:0] initial_code;
      logic [2:0]            initial_len;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic               busy_res;
      logic [TRIES_W-1:0] tries_left;
   } result_type;

endpackage
`default_nettype wire

// ===== sv/kpl_if.sv =====
`default_nettype none
interface kpl_req_if;
   logic                 valid;
   logic                 ready;
   kpl_pkg::opcode_type  opcode;
   kpl_pkg::char_type    key_code;

   modport source (output valid, output opcode, output key_code, input ready);
   modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

interface kpl_rsp_if;
   logic                             valid;
   logic                             ready;
   kpl_pkg::status_type              status;
   logic                             busy_res;
   logic [kpl_pkg::TRIES_W-1:0]      tries_left;

   modport source (output valid, output status, output busy_res, output tries_left, input ready);
   modport sink   (input valid, input status, input busy_res, input tries_left, output ready);
endinterface

interface kpl_csr_if;
   logic                              valid;
   logic                              ready;
   logic [kpl_pkg::CSR_INDEX_W-1:0]   index;
   logic [kpl_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/keypad_password_lock_top.sv =====
`default_nettype none
// Channel  Dir  Fields                          Word
// req      in   opcode[1:0], key_code[7:0]      one keypad event
// rsp      out  status[3:0], busy_res,          one result per event
//               tries_left[2:0]
// csr      in   index[1:0], data[55:0]          one register write
//
// One event per cycle unless a held result stalls req; its result appears in the output register the next cycle.
// The session logic and the entry compare sit between the accepted event and
// the output register, so the output register alone sets the pace.
// A held result stalls req only when rsp is not taken in that same cycle.
// Synchronous reset: idle session, empty password, max_tries 3; no clearing pass.
module keypad_password_lock_top (
   input  logic      clock,
   input  logic      reset,
   kpl_req_if.sink   req,
   kpl_rsp_if.source rsp,
   kpl_csr_if.sink   csr
);
   import kpl_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       fire;

   assign req.ready    = !rsp_valid_ff || rsp.ready;
   assign fire         = req.valid && req.ready;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp.ready);

   kpl_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   kpl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .opcode   (req.opcode),
      .key_code (req.key_code),
      .cfg      (cfg),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_data_ff.status;
   assign rsp.busy_res   = rsp_data_ff.busy_res;
   assign rsp.tries_left = rsp_data_ff.tries_left;
endmodule
`default_nettype wire

// ===== sv/kpl_csr.sv =====
`default_nettype none
module kpl_csr (
   input  logic              clock,
   input  logic              reset,
   kpl_csr_if.sink           csr,
   output kpl_pkg::cfg_type  cfg
);
   import kpl_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_MAX_TRIES: cfg_in.max_tries    = csr.data[TRIES_W-1:0];
            CSR_INIT_CODE: cfg_in.initial_code = csr.data;
            CSR_INIT_LEN:  cfg_in.initial_len  = csr.data[2:0];
            default:       cfg_in = cfg_ff;   // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_tries    <= MAX_TRIES_RESET;
         cfg_ff.initial_code <= '0;
         cfg_ff.initial_len  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// ===== sv/kpl_core.sv =====
`default_nettype none
module kpl_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  kpl_pkg::opcode_type  opcode,
   input  kpl_pkg::char_type    key_code,
   input  kpl_pkg::cfg_type     cfg,
   output kpl_pkg::result_type  result
);
   import kpl_pkg::*;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_CHECK   = 5'b00010,
      MODE_OLD     = 5'b00100,
      MODE_NEW     = 5'b01000,
      MODE_CONFIRM = 5'b10000
   } mode_type;

   mode_type           mode_ff, mode_in;
   logic [TRIES_W-1:0] tries_ff, tries_in;
   len_type            entry_len_ff, entry_len_in;
   len_type            new_len_ff, new_len_in;
   len_type            stored_len_ff, stored_len_in;
   char_type           entry_ff  [ENTRY_CAP];
   char_type           entry_in  [ENTRY_CAP];
   char_type           new_ff    [ENTRY_CAP];
   char_type           new_in    [ENTRY_CAP];
   char_type           stored_ff [ENTRY_CAP];
   char_type           stored_in [ENTRY_CAP];

   logic               stored_match;
   logic               new_match;
   len_type            load_len;
   logic               load_run;
   logic [TRIES_W-1:0] tries_bump;
   status_type         status;

   // entry vs stored / entry vs new, bytes past the length don't count
   always_comb begin
      stored_match = (entry_len_ff == stored_len_ff);
      new_match    = (entry_len_ff == new_len_ff);
      for (int i = 0; i < ENTRY_CAP; i++) begin
         if (len_type'(i) < entry_len_ff) begin
            if (entry_ff[i] != stored_ff[i]) stored_match = 1'b0;
            if (entry_ff[i] != new_ff[i])    new_match    = 1'b0;
         end
      end
   end

   // load length: limited by initial_len, stops at the first zero byte
   always_comb begin
      load_len = '0;
      load_run = 1'b1;
      for (int i = 0; i < LOAD_BYTES; i++) begin
         if (load_run && (3'(i) < cfg.initial_len) &&
             (cfg.initial_code[8*i +: 8] != KEY_NONE)) begin
            load_len = len_type'(i + 1);
         end else begin
            load_run = 1'b0;
         end
      end
   end

   assign tries_bump = (tries_ff != TRIES_SAT) ? tries_ff + TRIES_W'(1) : tries_ff;

   always_comb begin
      mode_in       = mode_ff;
      tries_in      = tries_ff;
      entry_len_in  = entry_len_ff;
      new_len_in    = new_len_ff;
      stored_len_in = stored_len_ff;
      entry_in      = entry_ff;
      new_in        = new_ff;
      stored_in     = stored_ff;
      status        = ST_IGNORED;

      unique case (opcode)
         OP_CHECK: begin
            mode_in      = MODE_CHECK;
            tries_in     = '0;
            entry_len_in = '0;
            status       = ST_STARTED;
         end
         OP_CHANGE: begin
            mode_in      = MODE_OLD;
            tries_in     = '0;
            entry_len_in = '0;
            status       = ST_STARTED;
         end
         OP_LOAD: begin
            for (int i = 0; i < LOAD_BYTES; i++) begin
               stored_in[i] = cfg.initial_code[8*i +: 8];
            end
            stored_len_in = load_len;
            status        = ST_UPDATED;
         end
         OP_KEY: begin
            if (mode_ff != MODE_IDLE && key_code != KEY_NONE) begin
               if (key_code == KEY_END) begin
                  entry_len_in = '0;
                  unique case (mode_ff)
                     MODE_CHECK: begin
                        if (stored_match) begin
                           mode_in  = MODE_IDLE;
                           tries_in = '0;
                           status   = ST_GRANTED;
                        end else if (tries_bump >= cfg.max_tries) begin
                           mode_in  = MODE_IDLE;
                           tries_in = '0;
                           status   = ST_LOCKED;
                        end else begin
                           tries_in = tries_bump;
                           status   = ST_RETRY;
                        end
                     end
                     MODE_OLD: begin
                        mode_in = stored_match ? MODE_NEW : MODE_IDLE;
                        status  = stored_match ? ST_ASK_NEW : ST_OLD_BAD;
                     end
                     MODE_NEW: begin
                        new_in     = entry_ff;
                        new_len_in = entry_len_ff;
                        mode_in    = MODE_CONFIRM;
                        status     = ST_ASK_CONF;
                     end
                     MODE_CONFIRM: begin
                        if (new_match) begin
                           stored_in     = new_ff;
                           stored_len_in = new_len_ff;
                           status        = ST_UPDATED;
                        end else begin
                           status = ST_MISMATCH;
                        end
                        mode_in = MODE_IDLE;
                     end
                     default: status = ST_IGNORED;
                  endcase
               end else if (entry_len_ff < len_type'(ENTRY_CAP)) begin
                  entry_in[entry_len_ff] = key_code;
                  entry_len_in           = entry_len_ff + len_type'(1);
                  status                 = ST_ECHO;
               end else begin
                  status = ST_DROPPED;
               end
            end
         end
      endcase
   end

   always_comb begin
      result.status     = status;
      result.busy_res   = (mode_in != MODE_IDLE);
      result.tries_left = (mode_in == MODE_CHECK && cfg.max_tries > tries_in) ?
                          cfg.max_tries - tries_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         tries_ff      <= '0;
         entry_len_ff  <= '0;
         new_len_ff    <= '0;
         stored_len_ff <= '0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         tries_ff      <= tries_in;
         entry_len_ff  <= entry_len_in;
         new_len_ff    <= new_len_in;
         stored_len_ff <= stored_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         entry_ff  <= entry_in;
         new_ff    <= new_in;
         stored_ff <= stored_in;
      end
   end
endmodule
`default_nettype wire
